FILE: hdl/i2cm_pkg.sv
// shared types and constants for the i2c master register transfer sequencer
`default_nettype none

package i2cm_pkg;

    // default depth of the data byte store
    localparam int BUF_DEPTH_DEF = 32;

    // direction bit of the device address byte
    localparam logic [7:0] DIR_READ = 8'h01;

    // widths of the packed stream payloads
    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_EVENT = 2'd2,
        ACT_ERROR = 2'd3
    } t_action;

    // input item fields, last member in the lowest bits
    typedef struct packed {
        logic        flag_rx_full;
        logic        flag_byte_done;
        logic        flag_tx_empty;
        logic        flag_addr_sent;
        logic        flag_start_sent;
        logic [5:0]  length;
        logic [1:0]  reg_bytes;
        logic [15:0] reg_ptr;
        logic [7:0]  slave_addr;
        logic [7:0]  data_byte;
        logic [4:0]  index;
    } t_item;

    // result item fields, last member in the lowest bits
    typedef struct packed {
        logic        busy_res;
        logic [7:0]  rx_byte;
        logic [4:0]  rx_index;
        logic        rx_valid;
        logic        clear_addr_flag;
        logic        ack_off;
        logic        gen_stop;
        logic        gen_start;
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic [7:0]  address_byte;
        logic        send_address;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/i2cm_store.sv
// data byte store: one write port, one registered read port with write forwarding
`default_nettype none

module i2cm_store #(
    parameter int BUF_DEPTH = i2cm_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [(BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [7:0]                                 i_wdata,
    input  wire logic [(BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1)-1:0] i_raddr,
    output logic      [7:0]                                 o_rdata
);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rdata;

    // write port and registered read, a same-cycle write to the read address wins
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/i2cm_seq.sv
// transfer sequencer: phase state, frame counters and the per-item result logic
`default_nettype none

module i2cm_seq #(
    parameter int BUF_DEPTH = i2cm_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_step,
    input  wire i2cm_pkg::t_action                          i_act,
    input  wire i2cm_pkg::t_item                            i_item,
    input  wire logic [7:0]                                 i_rd_data,
    output i2cm_pkg::t_result                               o_res,
    output logic                                            o_we,
    output logic [(BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1)-1:0] o_waddr,
    output logic [7:0]                                      o_wdata,
    output logic [(BUF_DEPTH > 1 ? $clog2(BUF_DEPTH) : 1)-1:0] o_raddr
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_W_START   = 5'd1,
        PH_W_ADDR    = 5'd2,
        PH_W_REG     = 5'd3,
        PH_W_REGWAIT = 5'd4,
        PH_W_DATA    = 5'd5,
        PH_W_STOP    = 5'd6,
        PH_R_START   = 5'd7,
        PH_R_ADDR    = 5'd8,
        PH_R_REG     = 5'd9,
        PH_R_REGWAIT = 5'd10,
        PH_R_RSTART  = 5'd11,
        PH_R_RADDR   = 5'd12,
        PH_R_DATA    = 5'd13
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [5:0]  r_byte_pos,  n_byte_pos;
    logic [5:0]  r_frame_len, n_frame_len;
    logic [1:0]  r_reg_left,  n_reg_left;
    logic [15:0] r_reg_word,  n_reg_word;
    logic [7:0]  r_target,    n_target;
    logic        r_busy,      n_busy;
    logic        reg_done;
    logic [5:0]  pos_inc;

    assign pos_inc = r_byte_pos + 6'd1;

    // next state and result for the item being consumed
    always_comb begin
        n_phase     = r_phase;
        n_byte_pos  = r_byte_pos;
        n_frame_len = r_frame_len;
        n_reg_left  = r_reg_left;
        n_reg_word  = r_reg_word;
        n_target    = r_target;
        n_busy      = r_busy;
        o_res       = '0;
        o_we        = 1'b0;
        o_waddr     = AW'(i_item.index);
        o_wdata     = i_item.data_byte;
        reg_done    = 1'b0;

        // register address byte, high byte first
        if ((r_phase == PH_W_REG || r_phase == PH_R_REG) && i_item.flag_tx_empty) begin
            if (r_reg_left > 2'd1) begin
                n_reg_left = r_reg_left - 2'd1;
            end else begin
                n_reg_left = 2'd0;
                reg_done   = 1'b1;
            end
        end

        if (i_step) begin
            case (i_act)
                i2cm_pkg::ACT_LOAD: begin
                    if (32'(i_item.index) < BUF_DEPTH) begin
                        o_we = 1'b1;
                    end
                    n_reg_left = r_reg_left;
                end
                i2cm_pkg::ACT_BEGIN: begin
                    n_reg_left = r_reg_left;
                    if (!r_busy && (i_item.length != 6'd0)) begin
                        if (32'(i_item.length) > BUF_DEPTH) begin
                            n_frame_len = 6'(BUF_DEPTH);
                        end else begin
                            n_frame_len = i_item.length;
                        end
                        case (i_item.reg_bytes)
                            2'd0:    n_reg_left = 2'd1;
                            2'd3:    n_reg_left = 2'd2;
                            default: n_reg_left = i_item.reg_bytes;
                        endcase
                        n_target        = i_item.slave_addr;
                        n_reg_word      = i_item.reg_ptr;
                        n_byte_pos      = 6'd0;
                        n_busy          = 1'b1;
                        o_res.gen_start = 1'b1;
                        n_phase = (i_item.slave_addr[0]) ? PH_R_START : PH_W_START;
                    end
                end
                i2cm_pkg::ACT_ERROR: begin
                    n_reg_left     = r_reg_left;
                    o_res.gen_stop = 1'b1;
                    n_phase        = PH_IDLE;
                    n_busy         = 1'b0;
                    n_byte_pos     = 6'd0;
                    n_frame_len    = 6'd0;
                end
                default: begin
                    // bus event, advance only on the awaited flag, but the stop phase takes any event
                    case (r_phase)
                        PH_W_START, PH_R_START: begin
                            if (i_item.flag_start_sent) begin
                                o_res.send_address = 1'b1;
                                o_res.address_byte = r_target & ~i2cm_pkg::DIR_READ;
                                n_phase = (r_phase == PH_W_START) ? PH_W_ADDR : PH_R_ADDR;
                            end
                        end
                        PH_W_ADDR, PH_R_ADDR: begin
                            if (i_item.flag_addr_sent) begin
                                o_res.clear_addr_flag = 1'b1;
                                n_phase = (r_phase == PH_W_ADDR) ? PH_W_REG : PH_R_REG;
                            end
                        end
                        PH_W_REG, PH_R_REG: begin
                            if (i_item.flag_tx_empty) begin
                                o_res.tx_valid = 1'b1;
                                o_res.tx_byte  = (r_reg_left > 2'd1) ? r_reg_word[15:8]
                                                                     : r_reg_word[7:0];
                                if (reg_done) begin
                                    if (r_phase == PH_R_REG) begin
                                        o_res.gen_start = 1'b1;
                                        n_phase         = PH_R_REGWAIT;
                                    end else begin
                                        n_phase = PH_W_REGWAIT;
                                    end
                                end
                            end
                        end
                        PH_W_REGWAIT: begin
                            if (i_item.flag_byte_done) begin
                                n_phase = PH_W_DATA;
                            end
                        end
                        PH_R_REGWAIT: begin
                            if (i_item.flag_byte_done) begin
                                n_phase = PH_R_RSTART;
                            end
                        end
                        PH_W_DATA: begin
                            if (i_item.flag_tx_empty) begin
                                o_res.tx_valid = 1'b1;
                                o_res.tx_byte  = (32'(r_byte_pos) < BUF_DEPTH) ? i_rd_data
                                                                              : 8'd0;
                                n_byte_pos = pos_inc;
                                if (pos_inc >= r_frame_len) begin
                                    n_phase = PH_W_STOP;
                                end
                            end
                        end
                        PH_W_STOP: begin
                            o_res.gen_stop = 1'b1;
                            n_phase        = PH_IDLE;
                            n_busy         = 1'b0;
                            n_byte_pos     = 6'd0;
                            n_frame_len    = 6'd0;
                        end
                        PH_R_RSTART: begin
                            if (i_item.flag_start_sent) begin
                                o_res.send_address = 1'b1;
                                o_res.address_byte = r_target | i2cm_pkg::DIR_READ;
                                n_phase = PH_R_RADDR;
                            end
                        end
                        PH_R_RADDR: begin
                            if (i_item.flag_addr_sent) begin
                                o_res.clear_addr_flag = 1'b1;
                                n_phase = PH_R_DATA;
                            end
                        end
                        PH_R_DATA: begin
                            if (i_item.flag_rx_full) begin
                                o_res.ack_off  = (pos_inc == r_frame_len);
                                o_we           = (32'(r_byte_pos) < BUF_DEPTH);
                                o_waddr        = AW'(r_byte_pos);
                                o_res.rx_valid = 1'b1;
                                o_res.rx_index = r_byte_pos[4:0];
                                o_res.rx_byte  = i_item.data_byte;
                                n_byte_pos     = pos_inc;
                                if (pos_inc >= r_frame_len) begin
                                    o_res.gen_stop = 1'b1;
                                    n_phase        = PH_IDLE;
                                    n_busy         = 1'b0;
                                    n_byte_pos     = 6'd0;
                                    n_frame_len    = 6'd0;
                                end
                            end
                        end
                        PH_IDLE: begin
                        end
                        default: begin
                            n_phase     = PH_IDLE;
                            n_busy      = 1'b0;
                            n_byte_pos  = 6'd0;
                            n_frame_len = 6'd0;
                        end
                    endcase
                end
            endcase
        end else begin
            n_reg_left = r_reg_left;
        end
        o_res.busy_res = n_busy;
    end

    // store read address follows the position the next item will see
    assign o_raddr = AW'(n_byte_pos);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_byte_pos  <= 6'd0;
            r_frame_len <= 6'd0;
            r_reg_left  <= 2'd0;
            r_reg_word  <= 16'd0;
            r_target    <= 8'd0;
            r_busy      <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_frame_len <= n_frame_len;
            r_reg_left  <= n_reg_left;
            r_reg_word  <= n_reg_word;
            r_target    <= n_target;
            r_busy      <= n_busy;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/i2c_master_register_transfer_fsm.sv
// Usage:
// The input stream carries one item per handshake: tuser holds the item kind (load a
// store byte, begin a frame, bus event with controller flags, bus error) and tdata the
// item fields. Every accepted item produces exactly one result item on the output
// stream, holding the controller commands (address phase, transmit byte, start, stop,
// acknowledge off, address flag clear), any received byte and the busy status.
// Items pass an input register, the sequencing logic and an output register: a result
// is registered into the output register when its item leaves the input register;
// one item per cycle is sustained while the receiver does not stall the output.
// The data store is a memory with a registered read port; its read address tracks the
// next transmit position every cycle, so a load followed at once by a transfer is safe.
// Store contents are not cleared at reset; the user must load bytes before a write
// frame; the block does not enforce it. Reset (synchronous, active low) returns the
// sequencer to idle and clears the counters and both stream valid flags.
// When the output is stalled the finished result holds and one more item is still
// taken into the input register; further input is held off until the result leaves.
`default_nettype none

module i2c_master_register_transfer_fsm #(
    parameter int BUF_DEPTH = i2cm_pkg::BUF_DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // index, data_byte, slave_addr, reg_ptr, reg_bytes, length, flag_start_sent,
    // flag_addr_sent, flag_tx_empty, flag_byte_done, flag_rx_full, zero fill
    input  wire logic [i2cm_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // action
    input  wire logic [i2cm_pkg::IN_USER_W-1:0]      i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // send_address, address_byte, tx_valid, tx_byte, gen_start, gen_stop, ack_off,
    // clear_addr_flag, rx_valid, rx_index, rx_byte, busy_res, zero fill
    output logic      [i2cm_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata
);

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic              r_in_vld;
    i2cm_pkg::t_action r_act;
    i2cm_pkg::t_item   r_item;
    logic              r_out_vld;
    i2cm_pkg::t_result r_res;
    i2cm_pkg::t_result res;
    logic              step;
    logic              in_take;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [7:0]        wdata;
    logic [7:0]        rd_data;

    // an item moves on when the result register is free or being emptied
    assign step            = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || step;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
        if (in_take) begin
            r_act  <= i2cm_pkg::t_action'(i_s_axis_tuser);
            r_item <= i2cm_pkg::t_item'(i_s_axis_tdata[$bits(i2cm_pkg::t_item)-1:0]);
        end
    end

    i2cm_seq #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_act     (r_act),
        .i_item    (r_item),
        .i_rd_data (rd_data),
        .o_res     (res),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr)
    );

    i2cm_store #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (step) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(i2cm_pkg::OUT_DATA_W - $bits(i2cm_pkg::t_result))'(0), r_res};

    // every consumed item leaves a result behind
    a_step_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_m_axis_tvalid)
        else $error("consumed item left no result");

    // a bus error always ends in stop and not busy
    a_error_stop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && (r_act == i2cm_pkg::ACT_ERROR)) |=> (r_res.gen_stop && !r_res.busy_res))
        else $error("bus error did not stop the transfer");

    // address phase and byte transmit never share one result
    a_cmd_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(r_res.send_address && r_res.tx_valid))
        else $error("address phase and transmit in one result");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// testbench for the i2c master register transfer sequencer: directed items and random frames checked by a scoreboard
`timescale 1ns / 1ps

module tb_top;

    localparam int BUF_DEPTH = i2cm_pkg::BUF_DEPTH_DEF;
    localparam int ITEM_W    = $bits(i2cm_pkg::t_item);
    localparam int RES_W     = $bits(i2cm_pkg::t_result);

    // controller flags, packed as in the item: rx_full, byte_done, tx_empty, addr_sent, start_sent
    localparam logic [4:0] FL_NONE  = 5'b00000;
    localparam logic [4:0] FL_START = 5'b00001;
    localparam logic [4:0] FL_ADDR  = 5'b00010;
    localparam logic [4:0] FL_TX    = 5'b00100;
    localparam logic [4:0] FL_DONE  = 5'b01000;
    localparam logic [4:0] FL_RX    = 5'b10000;

    // sequencer phases of the predictor
    typedef enum logic [4:0] {
        PH_IDLE, PH_W_START, PH_W_ADDR, PH_W_REG, PH_W_REGWAIT, PH_W_DATA, PH_W_STOP,
        PH_R_START, PH_R_ADDR, PH_R_REG, PH_R_REGWAIT, PH_R_RSTART, PH_R_RADDR, PH_R_DATA
    } t_phase;

    // predicts the command item of every accepted item and checks the results in order
    class i2c_seq_scoreboard;
        t_phase            ph;
        logic [7:0]        store [BUF_DEPTH];
        bit                written [BUF_DEPTH];
        logic [5:0]        byte_pos;
        logic [5:0]        frame_len;
        logic [1:0]        reg_left;
        logic [15:0]       reg_word;
        logic [7:0]        target;
        logic              busy_q;
        i2cm_pkg::t_result pending_cmds [$];
        int                errors;
        int                n_items;
        int                n_write;
        int                n_read;
        int                n_abort;
        int                n_rx;

        function new();
            ph = PH_IDLE;
            byte_pos = '0;
            frame_len = '0;
            reg_left = '0;
            reg_word = '0;
            target = '0;
            busy_q = 1'b0;
            errors = 0;
            n_items = 0;
            n_write = 0;
            n_read = 0;
            n_abort = 0;
            n_rx = 0;
            foreach (store[i]) begin
                store[i] = '0;
                written[i] = 1'b0;
            end
        endfunction

        function void go_idle();
            ph = PH_IDLE;
            busy_q = 1'b0;
            byte_pos = '0;
            frame_len = '0;
        endfunction

        // work out the commands caused by one accepted item
        function void note_item(i2cm_pkg::t_action act, i2cm_pkg::t_item it);
            i2cm_pkg::t_result r;
            logic [5:0]        len;
            logic [1:0]        rb;
            r = '0;
            n_items++;
            case (act)
                i2cm_pkg::ACT_LOAD: begin
                    if (32'(it.index) < BUF_DEPTH) begin
                        store[it.index] = it.data_byte;
                        written[it.index] = 1'b1;
                    end
                end
                i2cm_pkg::ACT_BEGIN: begin
                    if (!busy_q && it.length != 0) begin
                        len = (it.length > BUF_DEPTH) ? 6'(BUF_DEPTH) : it.length;
                        rb = (it.reg_bytes == 0) ? 2'd1 :
                             (it.reg_bytes > 2) ? 2'd2 : it.reg_bytes;
                        target = it.slave_addr;
                        reg_word = it.reg_ptr;
                        reg_left = rb;
                        frame_len = len;
                        byte_pos = '0;
                        busy_q = 1'b1;
                        r.gen_start = 1'b1;
                        if (target[0]) begin
                            ph = PH_R_START;
                            n_read++;
                        end else begin
                            ph = PH_W_START;
                            n_write++;
                        end
                    end
                end
                i2cm_pkg::ACT_ERROR: begin
                    if (busy_q) n_abort++;
                    r.gen_stop = 1'b1;
                    go_idle();
                end
                default: begin
                    case (ph)
                        PH_W_START, PH_R_START: begin
                            if (it.flag_start_sent) begin
                                r.send_address = 1'b1;
                                r.address_byte = target & ~i2cm_pkg::DIR_READ;
                                ph = (ph == PH_W_START) ? PH_W_ADDR : PH_R_ADDR;
                            end
                        end
                        PH_W_ADDR, PH_R_ADDR: begin
                            if (it.flag_addr_sent) begin
                                r.clear_addr_flag = 1'b1;
                                ph = (ph == PH_W_ADDR) ? PH_W_REG : PH_R_REG;
                            end
                        end
                        // register address bytes, high byte first
                        PH_W_REG, PH_R_REG: begin
                            if (it.flag_tx_empty) begin
                                r.tx_valid = 1'b1;
                                if (reg_left > 1) begin
                                    r.tx_byte = reg_word[15:8];
                                    reg_left = reg_left - 1'b1;
                                end else begin
                                    r.tx_byte = reg_word[7:0];
                                    reg_left = '0;
                                    if (ph == PH_R_REG) begin
                                        r.gen_start = 1'b1;
                                        ph = PH_R_REGWAIT;
                                    end else begin
                                        ph = PH_W_REGWAIT;
                                    end
                                end
                            end
                        end
                        PH_W_REGWAIT: if (it.flag_byte_done) ph = PH_W_DATA;
                        PH_R_REGWAIT: if (it.flag_byte_done) ph = PH_R_RSTART;
                        PH_W_DATA: begin
                            if (it.flag_tx_empty) begin
                                r.tx_valid = 1'b1;
                                r.tx_byte = store[byte_pos[4:0]];
                                byte_pos = byte_pos + 1'b1;
                                if (byte_pos >= frame_len) ph = PH_W_STOP;
                            end
                        end
                        // any event closes a write frame
                        PH_W_STOP: begin
                            r.gen_stop = 1'b1;
                            go_idle();
                        end
                        PH_R_RSTART: begin
                            if (it.flag_start_sent) begin
                                r.send_address = 1'b1;
                                r.address_byte = target | i2cm_pkg::DIR_READ;
                                ph = PH_R_RADDR;
                            end
                        end
                        PH_R_RADDR: begin
                            if (it.flag_addr_sent) begin
                                r.clear_addr_flag = 1'b1;
                                ph = PH_R_DATA;
                            end
                        end
                        PH_R_DATA: begin
                            if (it.flag_rx_full) begin
                                if (7'(byte_pos) + 7'd1 == 7'(frame_len)) r.ack_off = 1'b1;
                                store[byte_pos[4:0]] = it.data_byte;
                                written[byte_pos[4:0]] = 1'b1;
                                r.rx_valid = 1'b1;
                                r.rx_index = byte_pos[4:0];
                                r.rx_byte = it.data_byte;
                                n_rx++;
                                byte_pos = byte_pos + 1'b1;
                                if (byte_pos >= frame_len) begin
                                    r.gen_stop = 1'b1;
                                    go_idle();
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
            r.busy_res = busy_q;
            pending_cmds.push_back(r);
        endfunction

        function void cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one result item with the oldest prediction
        function void check_cmd(logic [i2cm_pkg::OUT_DATA_W-1:0] raw);
            i2cm_pkg::t_result got;
            i2cm_pkg::t_result want;
            got = raw[RES_W-1:0];
            if (pending_cmds.size() == 0) begin
                $error("result %h with no item waiting", raw);
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            cmp("send_address", want.send_address, got.send_address);
            cmp("address_byte", want.address_byte, got.address_byte);
            cmp("tx_valid", want.tx_valid, got.tx_valid);
            cmp("tx_byte", want.tx_byte, got.tx_byte);
            cmp("gen_start", want.gen_start, got.gen_start);
            cmp("gen_stop", want.gen_stop, got.gen_stop);
            cmp("ack_off", want.ack_off, got.ack_off);
            cmp("clear_addr_flag", want.clear_addr_flag, got.clear_addr_flag);
            cmp("rx_valid", want.rx_valid, got.rx_valid);
            cmp("rx_index", want.rx_index, got.rx_index);
            cmp("rx_byte", want.rx_byte, got.rx_byte);
            cmp("busy_res", want.busy_res, got.busy_res);
            cmp("zero fill", '0, raw[i2cm_pkg::OUT_DATA_W-1:RES_W]);
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_valid = 1'b0;
    i2cm_pkg::t_item                 s_item = '0;
    logic [i2cm_pkg::IN_USER_W-1:0]  s_user = i2cm_pkg::ACT_LOAD;
    logic                            m_ready = 1'b0;
    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic [i2cm_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [i2cm_pkg::IN_DATA_W-1:0]  s_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    i2c_seq_scoreboard sb;

    assign s_tdata = {{(i2cm_pkg::IN_DATA_W - ITEM_W){1'b0}}, s_item};

    i2c_master_register_transfer_fsm DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // receiver back pressure
    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // sample both handshakes; results are checked before the new item is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) sb.check_cmd(o_m_axis_tdata);
            if (s_valid && o_s_axis_tready)
                sb.note_item(i2cm_pkg::t_action'(s_user), s_item);
        end
    end

    function automatic i2cm_pkg::t_item mk_item(logic [4:0] idx, logic [7:0] db,
                                                logic [7:0] dev, logic [15:0] ra,
                                                logic [1:0] rb, logic [5:0] len,
                                                logic [4:0] flags);
        return {flags, len, rb, ra, dev, db, idx};
    endfunction

    // present one item, entered and left at a falling edge
    task automatic send_item(input i2cm_pkg::t_action act, input i2cm_pkg::t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        s_user <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // one random item, mostly the event that the current phase waits for
    task automatic send_random_item();
        i2cm_pkg::t_item it;
        logic [63:0]     rnd;
        int              r;
        int              eff;
        int              i;
        rnd = {$urandom, $urandom};
        it = rnd[ITEM_W-1:0];
        r = $urandom_range(99);
        if (r < 2) begin
            send_item(i2cm_pkg::ACT_ERROR, it);
        end else if (r < 6) begin
            send_item(i2cm_pkg::ACT_LOAD, it);
        end else if (r < 9) begin
            send_item(i2cm_pkg::ACT_EVENT, it);
        end else if (r < 11 || sb.ph == PH_IDLE) begin
            // begin a frame, mostly short ones
            r = $urandom_range(99);
            if (r < 8) it.length = 6'd0;
            else if (r < 16) it.length = 6'($urandom_range(33, 63));
            else if (r < 20) it.length = 6'(BUF_DEPTH);
            else it.length = 6'($urandom_range(1, 6));
            // a write frame only sends store entries that hold data
            if (!it.slave_addr[0] && !sb.busy_q) begin
                eff = (it.length > BUF_DEPTH) ? BUF_DEPTH : int'(it.length);
                for (i = 0; i < eff; i++) begin
                    if (!sb.written[i])
                        send_item(i2cm_pkg::ACT_LOAD,
                                  mk_item(5'(i), 8'($urandom), 8'($urandom),
                                          16'($urandom), 2'($urandom),
                                          6'($urandom), 5'($urandom)));
                end
            end
            send_item(i2cm_pkg::ACT_BEGIN, it);
        end else begin
            case (sb.ph)
                PH_W_START, PH_R_START, PH_R_RSTART: it.flag_start_sent = 1'b1;
                PH_W_ADDR, PH_R_ADDR, PH_R_RADDR:    it.flag_addr_sent = 1'b1;
                PH_W_REG, PH_R_REG, PH_W_DATA:       it.flag_tx_empty = 1'b1;
                PH_W_REGWAIT, PH_R_REGWAIT:          it.flag_byte_done = 1'b1;
                PH_R_DATA:                           it.flag_rx_full = 1'b1;
                default: ;
            endcase
            send_item(i2cm_pkg::ACT_EVENT, it);
        end
    endtask

    // run limit
    initial begin
        #5_000_000;
        $display("i2c_master_register_transfer_fsm test failed");
        $finish;
    end

    initial begin
        int p;
        int n;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: error and event while idle
        send_item(i2cm_pkg::ACT_ERROR,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_NONE));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'h1F, 8'hFF, 8'hFF, 16'hFFFF, 2'd3, 6'h3F, 5'h1F));
        // store extremes
        send_item(i2cm_pkg::ACT_LOAD,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_NONE));
        send_item(i2cm_pkg::ACT_LOAD,
                  mk_item(5'd1, 8'hFF, 8'h00, 16'h0000, 2'd0, 6'd0, FL_NONE));
        send_item(i2cm_pkg::ACT_LOAD,
                  mk_item(5'h1F, 8'h5A, 8'h00, 16'h0000, 2'd0, 6'd0, FL_NONE));
        // write frame with two register bytes and two data bytes, begin while busy
        send_item(i2cm_pkg::ACT_BEGIN,
                  mk_item(5'd0, 8'h00, 8'hFE, 16'hFFFF, 2'd2, 6'd2, FL_NONE));
        send_item(i2cm_pkg::ACT_BEGIN,
                  mk_item(5'd0, 8'h00, 8'h01, 16'h1234, 2'd1, 6'd1, FL_NONE));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_START));
        // event without the awaited flag
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_NONE));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_ADDR));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_TX));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_TX));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_DONE));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_TX));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_TX));
        // stop phase takes any event
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_NONE));
        // zero length is ignored
        send_item(i2cm_pkg::ACT_BEGIN,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd1, 6'd0, FL_NONE));
        // read frame, register byte count zero, one data byte
        send_item(i2cm_pkg::ACT_BEGIN,
                  mk_item(5'd0, 8'h00, 8'h01, 16'h0000, 2'd0, 6'd1, FL_NONE));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_START));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_ADDR));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_TX));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_DONE));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_START));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'h00, 8'h00, 16'h0000, 2'd0, 6'd0, FL_ADDR));
        send_item(i2cm_pkg::ACT_EVENT,
                  mk_item(5'd0, 8'hFF, 8'h00, 16'h0000, 2'd0, 6'd0, FL_RX));

        // random frames under four pressure settings
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (n = 0; n < 350; n++) send_random_item();
        end
        s_valid <= 1'b0;

        // drain the remaining results
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d items: %0d write and %0d read frames, %0d bytes received,",
                 sb.n_items, sb.n_write, sb.n_read, sb.n_rx);
        $display("%0d frames aborted by bus errors, under four idle and stall settings",
                 sb.n_abort);
        if (sb.errors == 0) begin
            $display("i2c_master_register_transfer_fsm test passed");
        end else begin
            $display("i2c_master_register_transfer_fsm test failed");
        end
        $finish;
    end

endmodule
